@@ hw/rtl/lcdlt_pkg.sv @@
// Package: shared types and constants for the LCD line timing and status block.
`default_nettype none
package lcdlt_pkg;

  localparam int DOT_W  = 10;
  localparam int LINE_W = 8;

  localparam logic [DOT_W-1:0]  OAM_END      = 10'd80;
  localparam logic [DOT_W-1:0]  TRANSFER_END = 10'd252;
  localparam logic [DOT_W-1:0]  COUNTER_MAX  = 10'd1023;
  localparam logic [LINE_W-1:0] LAST_LINE    = 8'd153;

  localparam logic [1:0] MODE_HBLANK   = 2'd0;
  localparam logic [1:0] MODE_VBLANK   = 2'd1;
  localparam logic [1:0] MODE_OAM      = 2'd2;
  localparam logic [1:0] MODE_TRANSFER = 2'd3;

  // bit positions in stat_enables
  localparam int EN_HBLANK = 0;
  localparam int EN_VBLANK = 1;
  localparam int EN_OAM    = 2;
  localparam int EN_COINC  = 3;

  typedef struct packed {
    logic [DOT_W-1:0]  dot_counter;
    logic [LINE_W-1:0] current_line;
    logic [1:0]        mode_reg;
    logic              coincidence_reg;
    logic              increment_enable;
  } lcdlt_state_t;

  typedef struct packed {
    logic [7:0] cycles;
    logic       lcd_enable;
    logic [3:0] stat_enables;
    logic [7:0] compare_line;
  } lcdlt_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       coincidence;
    logic [7:0] line_now;
    logic       stat_request;
    logic       vblank_request;
    logic       line_ready;
    logic [7:0] ready_line;
  } lcdlt_res_t;

endpackage
`default_nettype wire

@@ hw/rtl/lcdlt_in_if.sv @@
// Interface: input channel carrying one timing update word.
`default_nettype none
interface lcdlt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cycles;
  logic       lcd_enable;
  logic [3:0] stat_enables;
  logic [7:0] compare_line;

  modport source (output valid, cycles, lcd_enable, stat_enables, compare_line,
                  input ready);
  modport sink (input valid, cycles, lcd_enable, stat_enables, compare_line,
                output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lcdlt_out_if.sv @@
// Interface: result channel carrying one status word.
`default_nettype none
interface lcdlt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       coincidence;
  logic [7:0] line_now;
  logic       stat_request;
  logic       vblank_request;
  logic       line_ready;
  logic [7:0] ready_line;

  modport source (output valid, mode, coincidence, line_now, stat_request,
                  vblank_request, line_ready, ready_line, input ready);
  modport sink (input valid, mode, coincidence, line_now, stat_request,
                vblank_request, line_ready, ready_line, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lcdlt_step.sv @@
// Step logic: status phase and dot/line advance for one update word.
`default_nettype none
module lcdlt_step
  import lcdlt_pkg::*;
#(
  parameter int LINE_DOTS     = 456,
  parameter int VISIBLE_LINES = 144
) (
  input  lcdlt_state_t state,
  input  lcdlt_item_t  item,
  output lcdlt_state_t state_next,
  output lcdlt_res_t   res
);

  localparam logic [DOT_W-1:0]  LineDots = DOT_W'(LINE_DOTS);
  localparam logic [LINE_W-1:0] VisLines = LINE_W'(VISIBLE_LINES);

  logic [1:0]        mode;
  logic              want;
  logic              coinc;
  logic [DOT_W:0]    sum;
  logic [DOT_W-1:0]  dots;
  logic [LINE_W-1:0] line1;
  logic              inc1;
  logic              adv;

  always_comb begin
    state_next = state;
    res        = '0;
    mode       = MODE_VBLANK;
    want       = 1'b0;
    coinc      = (state.current_line == item.compare_line);
    sum        = {1'b0, state.dot_counter} + {3'b000, item.cycles};
    dots       = sum[DOT_W] ? COUNTER_MAX : sum[DOT_W-1:0];
    line1      = (state.current_line == LAST_LINE) ? '0 : state.current_line;
    inc1       = (state.current_line == LAST_LINE) ? 1'b0 : state.increment_enable;
    adv        = 1'b0;

    if (!item.lcd_enable) begin
      state_next.dot_counter  = '0;
      state_next.current_line = '0;
      state_next.mode_reg     = MODE_VBLANK;
      res.mode                = MODE_VBLANK;
    end else begin
      if (state.current_line >= VisLines) begin
        mode = MODE_VBLANK;
        want = item.stat_enables[EN_VBLANK];
      end else if (state.dot_counter < OAM_END) begin
        mode = MODE_OAM;
        want = item.stat_enables[EN_OAM];
      end else if (state.dot_counter < TRANSFER_END) begin
        mode = MODE_TRANSFER;
      end else begin
        mode = MODE_HBLANK;
        want = item.stat_enables[EN_HBLANK];
      end
      res.mode         = mode;
      res.stat_request = (want && mode != state.mode_reg) ||
                         (coinc && item.stat_enables[EN_COINC]);
      state_next.coincidence_reg  = coinc;
      state_next.mode_reg         = mode;
      state_next.dot_counter      = dots;
      state_next.current_line     = line1;
      state_next.increment_enable = inc1;

      if (dots >= LineDots) begin
        state_next.dot_counter = dots - LineDots;
        if (line1 == VisLines) begin
          res.vblank_request = 1'b1;
          adv = 1'b1;
        end else if (line1 == LAST_LINE) begin
          state_next.current_line = '0;
        end else if (line1 < VisLines) begin
          res.line_ready = 1'b1;
          res.ready_line = line1;
          adv = 1'b1;
        end else begin
          adv = 1'b1;
        end
      end

      // a skipped increment only re-arms the flag
      if (adv) begin
        if (inc1) begin
          state_next.current_line = line1 + 8'd1;
        end else begin
          state_next.increment_enable = 1'b1;
        end
      end
    end

    res.coincidence = state_next.coincidence_reg;
    res.line_now    = state_next.current_line;
  end

endmodule
`default_nettype wire

@@ hw/rtl/lcd_line_timing_status.sv @@
// LCD line timing and status unit: dot counter, scanline, mode and interrupt
// requests, one status word out for each update word in.
//
// din carries the elapsed cycles, LCD enable, STAT enables and LY compare
// value; dout returns mode, coincidence, current line, STAT and VBlank
// request pulses and the line-ready pulse with its line index.
// Path: a word accepted on din passes the input register, then the result
// register after the step logic, before it appears on dout.
// Throughput: one word per cycle while dout is not held off; the dot/line
// state is updated in the same cycle the word leaves the input register,
// so consecutive words chain. Stall: when dout is held off, the result
// register keeps its word and the input register can still take one more
// word; din.ready drops only once both are full.
// Reset (rst, synchronous): both registers empty, dot counter 3, line 0,
// mode hblank, coincidence 0, line increment armed.
`default_nettype none
module lcd_line_timing_status
  import lcdlt_pkg::*;
#(
  parameter int LINE_DOTS     = 456,
  parameter int VISIBLE_LINES = 144
) (
  input wire logic   clk,
  input wire logic   rst,
  lcdlt_in_if.sink   din,
  lcdlt_out_if.source dout
);

  logic         item_valid;
  lcdlt_item_t  item;
  logic         res_valid;
  lcdlt_res_t   res;
  lcdlt_state_t state;
  lcdlt_state_t state_next;
  lcdlt_res_t   res_next;
  logic         advance;
  logic         take_in;

  assign advance  = !res_valid || dout.ready;
  assign din.ready = !item_valid || advance;
  assign take_in  = din.valid && din.ready;

  lcdlt_step #(
    .LINE_DOTS     (LINE_DOTS),
    .VISIBLE_LINES (VISIBLE_LINES)
  ) u_step (
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take_in) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
    if (take_in) begin
      item.cycles       <= din.cycles;
      item.lcd_enable   <= din.lcd_enable;
      item.stat_enables <= din.stat_enables;
      item.compare_line <= din.compare_line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= item_valid;
    end
    if (advance && item_valid) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.dot_counter      <= 10'd3;
      state.current_line     <= '0;
      state.mode_reg         <= MODE_HBLANK;
      state.coincidence_reg  <= 1'b0;
      state.increment_enable <= 1'b1;
    end else if (advance && item_valid) begin
      state <= state_next;
    end
  end

  assign dout.valid          = res_valid;
  assign dout.mode           = res.mode;
  assign dout.coincidence    = res.coincidence;
  assign dout.line_now       = res.line_now;
  assign dout.stat_request   = res.stat_request;
  assign dout.vblank_request = res.vblank_request;
  assign dout.line_ready     = res.line_ready;
  assign dout.ready_line     = res.ready_line;

  a_line_range: assert property (@(posedge clk) disable iff (rst)
    state.current_line <= LAST_LINE)
    else $error("scanline beyond last line");

  a_one_pulse: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.vblank_request && res.line_ready))
    else $error("vblank and line-ready in one word");

  a_ready_idx: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.line_ready) |-> (res.ready_line < LINE_W'(VISIBLE_LINES)))
    else $error("ready line outside visible area");

  a_off_quiet: assert property (@(posedge clk) disable iff (rst)
    (advance && item_valid && !item.lcd_enable) |=>
      (state.current_line == '0 && !res.stat_request && res.mode == MODE_VBLANK))
    else $error("LCD off word did not clear state");

endmodule
`default_nettype wire
